// ===== sv/quaternion_to_rotation_matrix_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to rotation matrix core
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// Same-cycle implication
`define QRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrm: assertion failed");

// Next-cycle implication
`define QRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrm: assertion failed");

`endif

// ===== sv/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared constants for the quaternion to rotation matrix core.
// ----------------------------------------------------------------------------
`default_nettype none

package qrm_pkg;

  // Port widths
  localparam int IN_W  = 32;
  localparam int OUT_W = 16;

  // Default fixed-point formats
  localparam int DEF_IN_FRAC_BITS  = 16;
  localparam int DEF_OUT_FRAC_BITS = 14;

  // Quotient bits: output bits plus one rounding bit
  localparam int QUOT_W = OUT_W + 1;

  // Divider stages: magnitude stage, one stage per quotient bit, round stage
  localparam int DIV_LAT = QUOT_W + 2;

  // Rounded magnitude limits before saturation
  localparam logic [QUOT_W:0] RND_POS_LIM = (QUOT_W+1)'(2**(OUT_W-1) - 1);
  localparam logic [QUOT_W:0] RND_NEG_LIM = (QUOT_W+1)'(2**(OUT_W-1));

  // Saturated output codes
  localparam logic [OUT_W-1:0] OUT_POS_SAT = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_SAT = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== sv/quaternion_to_rotation_matrix_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// Converts the vector part of a unit quaternion into a 3x3 rotation matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_q_x, in_q_y, in_q_z (signed, IN_FRAC_BITS fraction bits) and
//   raise start; the word is taken at a clock edge where busy is low.
//   busy is high only during reset and the cycle after it, so a new word
//   can be taken on every clock.
//   Each matrix appears on out_r00..out_r22 (signed, OUT_FRAC_BITS fraction
//   bits, saturated) for exactly one cycle with out_strobe high, in the
//   order the words were taken.
//   Throughput is one matrix per clock.
//   The pipeline is the front end (three stages), the square root
//   (one root bit per stage, IN_FRAC_BITS + 1 stages so a root of one
//   fits), a product stage, a numerator stage and the nine output
//   dividers (one quotient bit per stage, plus a magnitude and a rounding
//   stage).
//   Reset (synchronous, rst_n low) drops every word in flight.
//   The receiver cannot stall: a result not captured in its cycle is gone.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_to_rotation_matrix_core_macros.svh"

module quaternion_to_rotation_matrix_core #(
  parameter int IN_FRAC_BITS  = qrm_pkg::DEF_IN_FRAC_BITS,
  parameter int OUT_FRAC_BITS = qrm_pkg::DEF_OUT_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [qrm_pkg::IN_W-1:0]  in_q_x,
  input  wire logic signed [qrm_pkg::IN_W-1:0]  in_q_y,
  input  wire logic signed [qrm_pkg::IN_W-1:0]  in_q_z,
  output logic                                  out_strobe,
  output logic signed [qrm_pkg::OUT_W-1:0]      out_r00,
  output logic signed [qrm_pkg::OUT_W-1:0]      out_r01,
  output logic signed [qrm_pkg::OUT_W-1:0]      out_r02,
  output logic signed [qrm_pkg::OUT_W-1:0]      out_r10,
  output logic signed [qrm_pkg::OUT_W-1:0]      out_r11,
  output logic signed [qrm_pkg::OUT_W-1:0]      out_r12,
  output logic signed [qrm_pkg::OUT_W-1:0]      out_r20,
  output logic signed [qrm_pkg::OUT_W-1:0]      out_r21,
  output logic signed [qrm_pkg::OUT_W-1:0]      out_r22
);

  localparam int F      = IN_FRAC_BITS;
  localparam int XW     = F + 2;
  localparam int PW     = 2*F + 2;
  localparam int DW     = 2*F + 2;
  localparam int VW     = 2*F + 4;
  localparam int SIDE_W = 3*XW + 6*PW + DW;
  localparam int DLAT   = qrm_pkg::DIV_LAT;
  localparam int LAT    = F + 6 + DLAT;
  localparam int SQW    = 2*F + 2;
  localparam int NL     = 9;

  // Hold busy through reset
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Front end: wrap, products, sum of squares
  logic                 fr_vld;
  logic signed [XW-1:0] fr_x, fr_y, fr_z;
  logic signed [PW-1:0] fr_x2, fr_y2, fr_z2, fr_xy, fr_xz, fr_yz;
  logic [DW-1:0]        fr_w2;
  logic [DW-1:0]        fr_d;

  qrm_front #(
    .IN_FRAC_BITS (IN_FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .q_x     (in_q_x),
    .q_y     (in_q_y),
    .q_z     (in_q_z),
    .out_vld (fr_vld),
    .out_x   (fr_x),
    .out_y   (fr_y),
    .out_z   (fr_z),
    .out_x2  (fr_x2),
    .out_y2  (fr_y2),
    .out_z2  (fr_z2),
    .out_xy  (fr_xy),
    .out_xz  (fr_xz),
    .out_yz  (fr_yz),
    .out_w2  (fr_w2),
    .out_d   (fr_d)
  );

  // Scalar part by square root, products ride along
  logic [SIDE_W-1:0]    sq_side_in, sq_side;
  logic                 sq_vld;
  logic [F:0]           sq_w;
  logic [DW-1:0]        sq_n;
  logic signed [XW-1:0] sx, sy, sz;
  logic signed [PW-1:0] sx2, sy2, sz2, sxy, sxz, syz;
  logic [DW-1:0]        sd;

  assign sq_side_in = {fr_x, fr_y, fr_z, fr_x2, fr_y2, fr_z2, fr_xy, fr_xz, fr_yz, fr_d};
  assign {sx, sy, sz, sx2, sy2, sz2, sxy, sxz, syz, sd} = sq_side;

  qrm_isqrt #(
    .ROOT_W (F + 1),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_n     (fr_w2),
    .in_side  (sq_side_in),
    .out_vld  (sq_vld),
    .out_root (sq_w),
    .out_n    (sq_n),
    .out_side (sq_side)
  );

  // Scalar times vector products
  logic signed [2*F+3:0] wx_full, wy_full, wz_full;
  logic                  wm_vld_r;
  logic signed [PW-1:0]  wm_wx_r, wm_wy_r, wm_wz_r;
  logic signed [PW-1:0]  wm_x2_r, wm_y2_r, wm_z2_r, wm_xy_r, wm_xz_r, wm_yz_r;
  logic [DW-1:0]         wm_w2_r;
  logic [DW-1:0]         wm_d_r;

  assign wx_full = $signed({1'b0, sq_w}) * sx;
  assign wy_full = $signed({1'b0, sq_w}) * sy;
  assign wz_full = $signed({1'b0, sq_w}) * sz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm_vld_r <= 1'b0;
    end else begin
      wm_vld_r <= sq_vld;
    end
    wm_wx_r <= $signed(wx_full[PW-1:0]);
    wm_wy_r <= $signed(wy_full[PW-1:0]);
    wm_wz_r <= $signed(wz_full[PW-1:0]);
    wm_x2_r <= sx2;
    wm_y2_r <= sy2;
    wm_z2_r <= sz2;
    wm_xy_r <= sxy;
    wm_xz_r <= sxz;
    wm_yz_r <= syz;
    wm_w2_r <= sq_n;
    wm_d_r  <= sd;
  end

  // Form the nine element numerators
  logic signed [VW-1:0] e_w2, e_x2, e_y2, e_z2, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
  logic signed [VW-1:0] v_nxt [NL];
  logic signed [VW-1:0] v_r   [NL];
  logic [DW-1:0]        vd_r;
  logic                 v_vld_r;

  assign e_w2 = $signed(VW'(wm_w2_r));
  assign e_x2 = VW'(wm_x2_r);
  assign e_y2 = VW'(wm_y2_r);
  assign e_z2 = VW'(wm_z2_r);
  assign e_xy = VW'(wm_xy_r);
  assign e_xz = VW'(wm_xz_r);
  assign e_yz = VW'(wm_yz_r);
  assign e_wx = VW'(wm_wx_r);
  assign e_wy = VW'(wm_wy_r);
  assign e_wz = VW'(wm_wz_r);

  assign v_nxt[0] = e_w2 + e_x2 - e_y2 - e_z2;
  assign v_nxt[1] = (e_xy + e_wz) <<< 1;
  assign v_nxt[2] = (e_xz - e_wy) <<< 1;
  assign v_nxt[3] = (e_xy - e_wz) <<< 1;
  assign v_nxt[4] = e_w2 - e_x2 + e_y2 - e_z2;
  assign v_nxt[5] = (e_yz + e_wx) <<< 1;
  assign v_nxt[6] = (e_xz + e_wy) <<< 1;
  assign v_nxt[7] = (e_yz - e_wx) <<< 1;
  assign v_nxt[8] = e_w2 - e_x2 - e_y2 + e_z2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r <= 1'b0;
    end else begin
      v_vld_r <= wm_vld_r;
    end
    for (int i = 0; i < NL; i++) begin
      v_r[i] <= v_nxt[i];
    end
    vd_r <= wm_d_r;
  end

  // Divide each element by the normalizer
  logic signed [qrm_pkg::OUT_W-1:0] lane_r [NL];

  for (genvar i = 0; i < NL; i++) begin : g_lane
    qrm_div #(
      .IN_FRAC_BITS  (IN_FRAC_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .v_in  (v_r[i]),
      .d_in  (vd_r),
      .r_out (lane_r[i])
    );
  end

  // Advance valid alongside the divider lanes
  logic [DLAT-1:0] dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else begin
      dv_r <= {dv_r[DLAT-2:0], v_vld_r};
    end
  end

  assign out_strobe = dv_r[DLAT-1];
  assign out_r00    = lane_r[0];
  assign out_r01    = lane_r[1];
  assign out_r02    = lane_r[2];
  assign out_r10    = lane_r[3];
  assign out_r11    = lane_r[4];
  assign out_r12    = lane_r[5];
  assign out_r20    = lane_r[6];
  assign out_r21    = lane_r[7];
  assign out_r22    = lane_r[8];

  // Root bounds for the square root output
  logic [SQW-1:0] chk_w, chk_w1, chk_n;

  assign chk_w  = SQW'(sq_w);
  assign chk_w1 = chk_w + SQW'(1);
  assign chk_n  = SQW'(sq_n);

  `QRM_ASSERT_NEXT(a_busy_low, rst_n, !busy)
  `QRM_ASSERT_NOW(a_strobe_source, out_strobe, $past(accept, LAT))
  `QRM_ASSERT_NOW(a_root_floor, sq_vld, ((chk_w * chk_w) <= chk_n) && ((chk_w1 * chk_w1) > chk_n))

endmodule

`default_nettype wire

// ===== sv/qrm_front.sv =====
// ----------------------------------------------------------------------------
// qrm_front
// Wraps the three components, forms squares and cross products, then the
// sum of squares, the squared scalar part and the divisor. Three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qrm_front #(
  parameter int IN_FRAC_BITS = qrm_pkg::DEF_IN_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_vld,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   q_x,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   q_y,
  input  wire logic signed [qrm_pkg::IN_W-1:0]   q_z,
  output logic                                   out_vld,
  output logic signed [IN_FRAC_BITS+1:0]         out_x,
  output logic signed [IN_FRAC_BITS+1:0]         out_y,
  output logic signed [IN_FRAC_BITS+1:0]         out_z,
  output logic signed [2*IN_FRAC_BITS+1:0]       out_x2,
  output logic signed [2*IN_FRAC_BITS+1:0]       out_y2,
  output logic signed [2*IN_FRAC_BITS+1:0]       out_z2,
  output logic signed [2*IN_FRAC_BITS+1:0]       out_xy,
  output logic signed [2*IN_FRAC_BITS+1:0]       out_xz,
  output logic signed [2*IN_FRAC_BITS+1:0]       out_yz,
  output logic [2*IN_FRAC_BITS+1:0]              out_w2,
  output logic [2*IN_FRAC_BITS+1:0]              out_d
);

  localparam int F  = IN_FRAC_BITS;
  localparam int XW = F + 2;
  localparam int PW = 2*F + 2;
  localparam int DW = 2*F + 2;
  localparam int EW = qrm_pkg::IN_W + 2;
  localparam logic signed [XW-1:0] ONE_X   = $signed(XW'(1) << F);
  localparam logic [DW-1:0]        ONE_SQ  = DW'(1) << (2*F);

  // Wrap one component with period two into [-1, 1]
  function automatic logic signed [XW-1:0] wrap_comp(input logic signed [qrm_pkg::IN_W-1:0] q);
    logic signed [EW-1:0] qe;
    logic signed [EW-1:0] one_e;
    logic [EW-1:0]        t;
    logic [F:0]           m;
    qe    = EW'(q);
    one_e = $signed(EW'(1) << F);
    t     = '0;
    m     = '0;
    if (qe > one_e) begin
      t = qe + one_e;
      m = t[F:0];
      wrap_comp = $signed(XW'(m)) - ONE_X;
    end else if (qe < -one_e) begin
      t = one_e - qe;
      m = t[F:0];
      wrap_comp = ONE_X - $signed(XW'(m));
    end else begin
      wrap_comp = $signed(qe[XW-1:0]);
    end
  endfunction

  // Stage 1: wrapped components
  logic                 w_vld_r;
  logic signed [XW-1:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r <= 1'b0;
    end else begin
      w_vld_r <= in_vld;
    end
    x_r <= wrap_comp(q_x);
    y_r <= wrap_comp(q_y);
    z_r <= wrap_comp(q_z);
  end

  // Stage 2: squares and cross products
  logic signed [2*XW-1:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz;
  logic                   p_vld_r;
  logic signed [XW-1:0]   px_r, py_r, pz_r;
  logic signed [PW-1:0]   xx_r, yy_r, zz_r, xy_r, xz_r, yz_r;

  assign p_xx = x_r * x_r;
  assign p_yy = y_r * y_r;
  assign p_zz = z_r * z_r;
  assign p_xy = x_r * y_r;
  assign p_xz = x_r * z_r;
  assign p_yz = y_r * z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= w_vld_r;
    end
    px_r <= x_r;
    py_r <= y_r;
    pz_r <= z_r;
    xx_r <= $signed(p_xx[PW-1:0]);
    yy_r <= $signed(p_yy[PW-1:0]);
    zz_r <= $signed(p_zz[PW-1:0]);
    xy_r <= $signed(p_xy[PW-1:0]);
    xz_r <= $signed(p_xz[PW-1:0]);
    yz_r <= $signed(p_yz[PW-1:0]);
  end

  // Stage 3: sum of squares, scalar part squared and divisor
  // (the squared scalar part reaches one exactly for a zero vector part)
  logic [DW-1:0]      s_sum;
  logic [DW-1:0]      w2_full;
  logic [DW-1:0]      w2_nxt;
  logic [DW-1:0]      d_nxt;

  assign s_sum   = DW'(xx_r) + DW'(yy_r) + DW'(zz_r);
  assign w2_full = ONE_SQ - s_sum;

  always_comb begin
    w2_nxt = '0;
    d_nxt  = ONE_SQ;
    if (s_sum < ONE_SQ) begin
      w2_nxt = w2_full;
    end else if (s_sum > ONE_SQ) begin
      d_nxt = s_sum;
    end
  end

  logic out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= p_vld_r;
    end
    out_x  <= px_r;
    out_y  <= py_r;
    out_z  <= pz_r;
    out_x2 <= xx_r;
    out_y2 <= yy_r;
    out_z2 <= zz_r;
    out_xy <= xy_r;
    out_xz <= xz_r;
    out_yz <= yz_r;
    out_w2 <= w2_nxt;
    out_d  <= d_nxt;
  end

  assign out_vld = out_vld_r;

endmodule

`default_nettype wire

// ===== sv/qrm_isqrt.sv =====
// ----------------------------------------------------------------------------
// qrm_isqrt
// Pipelined integer square root, one root bit per stage, with a side word
// that travels alongside. Result is the floor of the root.
// ----------------------------------------------------------------------------
`default_nettype none

module qrm_isqrt #(
  parameter int ROOT_W = qrm_pkg::DEF_IN_FRAC_BITS,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_vld,
  input  wire logic [2*ROOT_W-1:0]   in_n,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_vld,
  output logic [ROOT_W-1:0]          out_root,
  output logic [2*ROOT_W-1:0]        out_n,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int RW = 2*ROOT_W;

  logic              vld_r  [ROOT_W];
  logic [RW-1:0]     rem_r  [ROOT_W];
  logic [ROOT_W-1:0] res_r  [ROOT_W];
  logic [RW-1:0]     n_r    [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int K = ROOT_W - 1 - i;
    logic              prev_vld;
    logic [RW-1:0]     prev_rem;
    logic [ROOT_W-1:0] prev_res;
    logic [RW-1:0]     prev_n;
    logic [SIDE_W-1:0] prev_side;
    logic [RW:0]       trial;
    logic              take;

    if (i == 0) begin : g_first
      assign prev_vld  = in_vld;
      assign prev_rem  = in_n;
      assign prev_res  = '0;
      assign prev_n    = in_n;
      assign prev_side = in_side;
    end else begin : g_next
      assign prev_vld  = vld_r[i-1];
      assign prev_rem  = rem_r[i-1];
      assign prev_res  = res_r[i-1];
      assign prev_n    = n_r[i-1];
      assign prev_side = side_r[i-1];
    end

    // Try the next root bit: (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
    assign trial = ((RW+1)'(prev_res) << (K+1)) + ((RW+1)'(1) << (2*K));
    assign take  = {1'b0, prev_rem} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= prev_vld;
      end
      rem_r[i]  <= take ? (prev_rem - trial[RW-1:0]) : prev_rem;
      res_r[i]  <= take ? (prev_res | (ROOT_W'(1) << K)) : prev_res;
      n_r[i]    <= prev_n;
      side_r[i] <= prev_side;
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = res_r[ROOT_W-1];
  assign out_n    = n_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

`default_nettype wire

// ===== sv/qrm_div.sv =====
// ----------------------------------------------------------------------------
// qrm_div
// One output lane: takes a signed numerator and a divisor, gives the
// rounded, saturated quotient scaled by 2^OUT_FRAC_BITS. Restoring divider,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrm_div #(
  parameter int IN_FRAC_BITS  = qrm_pkg::DEF_IN_FRAC_BITS,
  parameter int OUT_FRAC_BITS = qrm_pkg::DEF_OUT_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic signed [2*IN_FRAC_BITS+3:0]  v_in,
  input  wire logic [2*IN_FRAC_BITS+1:0]         d_in,
  output logic signed [qrm_pkg::OUT_W-1:0]       r_out
);

  localparam int F  = IN_FRAC_BITS;
  localparam int VW = 2*F + 4;
  localparam int MW = VW - 1;
  localparam int DW = 2*F + 2;
  localparam int CW = 2*F + OUT_FRAC_BITS + 20;
  localparam int QW = qrm_pkg::QUOT_W;
  localparam int OW = qrm_pkg::OUT_W;

  // Stage 0: magnitude, scaled numerator and overflow check
  logic [MW-1:0]  mag;
  logic [CW-1:0]  n0;
  logic [CW-1:0]  lim;
  logic [CW-1:0]  s0_rem_r;
  logic [DW-1:0]  s0_d_r;
  logic           s0_neg_r;
  logic           s0_ovf_r;

  assign mag = v_in[VW-1] ? MW'(-v_in) : MW'(v_in);
  assign n0  = CW'(mag) << (OUT_FRAC_BITS + 1);
  assign lim = CW'(d_in) << QW;

  always_ff @(posedge clk) begin
    s0_rem_r <= n0;
    s0_d_r   <= d_in;
    s0_neg_r <= v_in[VW-1];
    s0_ovf_r <= n0 >= lim;
  end

  // Quotient stages, most significant bit first
  logic [CW-1:0] rem_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] d_r   [QW];
  logic          neg_r [QW];
  logic          ovf_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int B = QW - 1 - j;
    logic [CW-1:0] prev_rem;
    logic [QW-1:0] prev_q;
    logic [DW-1:0] prev_d;
    logic          prev_neg;
    logic          prev_ovf;
    logic [CW-1:0] dsh;
    logic          take;

    if (j == 0) begin : g_first
      assign prev_rem = s0_rem_r;
      assign prev_q   = '0;
      assign prev_d   = s0_d_r;
      assign prev_neg = s0_neg_r;
      assign prev_ovf = s0_ovf_r;
    end else begin : g_next
      assign prev_rem = rem_r[j-1];
      assign prev_q   = q_r[j-1];
      assign prev_d   = d_r[j-1];
      assign prev_neg = neg_r[j-1];
      assign prev_ovf = ovf_r[j-1];
    end

    assign dsh  = CW'(prev_d) << B;
    assign take = prev_rem >= dsh;

    always_ff @(posedge clk) begin
      rem_r[j] <= take ? (prev_rem - dsh) : prev_rem;
      q_r[j]   <= {prev_q[QW-2:0], take};
      d_r[j]   <= prev_d;
      neg_r[j] <= prev_neg;
      ovf_r[j] <= prev_ovf;
    end
  end

  // Round half away from zero, apply sign, saturate
  logic [QW:0]      rnd;
  logic [OW-1:0]    r_nxt;
  logic [OW-1:0]    r_r;

  assign rnd = ((QW+1)'(q_r[QW-1]) + (QW+1)'(1)) >> 1;

  always_comb begin
    if (neg_r[QW-1]) begin
      if (ovf_r[QW-1] || (rnd > qrm_pkg::RND_NEG_LIM)) begin
        r_nxt = qrm_pkg::OUT_NEG_SAT;
      end else begin
        r_nxt = -rnd[OW-1:0];
      end
    end else begin
      if (ovf_r[QW-1] || (rnd > qrm_pkg::RND_POS_LIM)) begin
        r_nxt = qrm_pkg::OUT_POS_SAT;
      end else begin
        r_nxt = rnd[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
  end

  assign r_out = $signed(r_r);

endmodule

`default_nettype wire
